// ===== hdl/pid_incremental_pwm_controller_top_defines.svh =====
// Assertion macros shared by the PID cooling regulator RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PID_INCREMENTAL_PWM_CONTROLLER_TOP_DEFINES_SVH
`define PID_INCREMENTAL_PWM_CONTROLLER_TOP_DEFINES_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidc: next-cycle check failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define PIDC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pidc: same-cycle check failed");

`endif

// ===== hdl/pidc_pkg.sv =====
// Shared constants, widths and register index codes for the PID cooling regulator.
// No dependencies; imported by pid_incremental_pwm_controller_top.
package pidc_pkg;

    localparam int TEMP_BITS      = 8;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int PULSE_BITS     = 16;

    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 10;
    localparam int PULSE_W  = 16;
    localparam int CORR_W   = 16;

    localparam int ERR_W     = TEMP_BITS + 1;
    localparam int DELTA_W   = ERR_W + 1;
    localparam int SUM_W     = LIMIT_W + 1;
    localparam int RAW_SUM_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;

    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W = GAIN_W + 1 + DELTA_W;
    localparam int PROD_MAX_W = (PROD_P_W > PROD_I_W) ?
                                ((PROD_P_W > PROD_D_W) ? PROD_P_W : PROD_D_W) :
                                ((PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W);
    localparam int ACC_W = PROD_MAX_W + 2;
    localparam int LVL_W = PULSE_W + 2;

    localparam logic [PULSE_W-1:0] PULSE_MAX   = PULSE_W'((64'd1 << PULSE_BITS) - 64'd1);
    localparam logic [PULSE_W-1:0] PULSE_RESET = PULSE_W'(10);
    localparam logic [ACC_W-1:0]   TRUNC_BIAS  = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_FIELDS_W  = TEMP_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = PULSE_W + CORR_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT       = 3'd0,
        CFG_PROP_GAIN      = 3'd1,
        CFG_INTEG_GAIN     = 3'd2,
        CFG_DERIV_GAIN     = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_PULSE_FLOOR    = 3'd5,
        CFG_PULSE_CEILING  = 3'd6,
        CFG_COOLING_ENABLE = 3'd7
    } t_cfg_idx;

    localparam logic [TEMP_BITS-1:0] SETPOINT_RESET   = TEMP_BITS'(10);
    localparam logic [GAIN_W-1:0]    PROP_GAIN_RESET  = GAIN_W'(768);
    localparam logic [GAIN_W-1:0]    INTEG_GAIN_RESET = GAIN_W'(26);
    localparam logic [GAIN_W-1:0]    DERIV_GAIN_RESET = GAIN_W'(256);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = LIMIT_W'(15);
    localparam logic [PULSE_W-1:0]   FLOOR_RESET      = PULSE_W'(0);
    localparam logic [PULSE_W-1:0]   CEILING_RESET    = PULSE_W'(999);

endpackage

// ===== hdl/pid_incremental_pwm_controller_top.sv =====
// PID cooling regulator: stream in temperature samples, stream out pulse widths.
// Depends on pidc_pkg and on pid_incremental_pwm_controller_top_defines.svh.
//
// Usage:
//   Input stream (i_s_axis_*): one measured temperature sample per item, in
//   tdata[7:0] as two's complement. Output stream (o_m_axis_*): one result per
//   sample: new pulse width, saturated PID correction and the integral clamp
//   flag. Configuration registers are written through i_cfg_wr_en / i_cfg_index /
//   i_cfg_data; the user must write them only while the block is idle, and the
//   block does not enforce this; an index beyond the list is ignored. A sample
//   accepted goes into the sample register, then through the error/integral
//   stage, the multiply stage and the correction/pulse stage into the output
//   register. Throughput: one item per cycle while o_m_axis_tready is high;
//   each stage holds a valid bit and moves on when the next stage is empty or
//   draining, so bubbles close up. The error sum and previous error update as
//   an item leaves the first stage; the kept pulse level updates as it leaves
//   the third stage, so back-to-back items see each other's state in order.
//   Reset: all stages empty, error sum and previous error zero, pulse level
//   ten, registers back to their defaults.
//   Stall: when the receiver holds o_m_axis_tready low the output register
//   holds its item; upstream stages keep filling until all are full, then
//   o_s_axis_tready drops.
`include "pid_incremental_pwm_controller_top_defines.svh"

module pid_incremental_pwm_controller_top
    import pidc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] measured_temp
    // output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [15:0] pulse_width, [31:16] correction, [32] integral_clamped, rest zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [TEMP_BITS-1:0] r_setpoint;
    logic [GAIN_W-1:0]           r_prop_gain;
    logic [GAIN_W-1:0]           r_integ_gain;
    logic [GAIN_W-1:0]           r_deriv_gain;
    logic [LIMIT_W-1:0]          r_limit;
    logic [PULSE_W-1:0]          r_floor;
    logic [PULSE_W-1:0]          r_ceiling;
    logic                        r_cool_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= SETPOINT_RESET;
            r_prop_gain  <= PROP_GAIN_RESET;
            r_integ_gain <= INTEG_GAIN_RESET;
            r_deriv_gain <= DERIV_GAIN_RESET;
            r_limit      <= LIMIT_RESET;
            r_floor      <= FLOOR_RESET;
            r_ceiling    <= CEILING_RESET;
            r_cool_en    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SETPOINT:       r_setpoint   <= i_cfg_data[TEMP_BITS-1:0];
                CFG_PROP_GAIN:      r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:     r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:     r_deriv_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: r_limit      <= i_cfg_data[LIMIT_W-1:0];
                CFG_PULSE_FLOOR:    r_floor      <= i_cfg_data[PULSE_W-1:0];
                CFG_PULSE_CEILING:  r_ceiling    <= i_cfg_data[PULSE_W-1:0];
                CFG_COOLING_ENABLE: r_cool_en    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage advances when the next one can take it
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic n_s1_valid, n_s2_valid, n_s3_valid, n_out_valid;
    logic out_rdy, s3_rdy, s2_rdy;
    logic in_acc, s1_mv, s2_mv, s3_mv;

    assign out_rdy = !r_out_valid || i_m_axis_tready;
    assign s3_rdy  = !r_s3_valid || out_rdy;
    assign s2_rdy  = !r_s2_valid || s3_rdy;
    assign o_s_axis_tready = !r_s1_valid || s2_rdy;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign s1_mv  = r_s1_valid && s2_rdy;
    assign s2_mv  = r_s2_valid && s3_rdy;
    assign s3_mv  = r_s3_valid && out_rdy;

    assign n_s1_valid  = in_acc || (r_s1_valid && !s2_rdy);
    assign n_s2_valid  = s1_mv  || (r_s2_valid && !s3_rdy);
    assign n_s3_valid  = s2_mv  || (r_s3_valid && !out_rdy);
    assign n_out_valid = s3_mv  || (r_out_valid && !i_m_axis_tready);

    // ------------------------------------------------------------------
    // Stage 1: error, integral update and clamp, error difference
    // ------------------------------------------------------------------
    logic signed [TEMP_BITS-1:0] r_s1_temp;
    logic signed [SUM_W-1:0]     r_err_sum;
    logic signed [ERR_W-1:0]     r_prev_err;

    logic signed [ERR_W-1:0]     s1_err;
    logic signed [RAW_SUM_W-1:0] s1_raw;
    logic signed [RAW_SUM_W-1:0] s1_lim_pos;
    logic signed [RAW_SUM_W-1:0] s1_lim_neg;
    logic                        s1_clamp_hi;
    logic                        s1_clamp_lo;
    logic signed [SUM_W-1:0]     s1_sum;
    logic signed [DELTA_W-1:0]   s1_delta;

    assign s1_err      = ERR_W'(r_setpoint) - ERR_W'(r_s1_temp);
    assign s1_raw      = RAW_SUM_W'(r_err_sum) + RAW_SUM_W'(s1_err);
    assign s1_lim_pos  = signed'(RAW_SUM_W'(r_limit));
    assign s1_lim_neg  = -s1_lim_pos;
    assign s1_clamp_hi = s1_raw > s1_lim_pos;
    assign s1_clamp_lo = s1_raw < s1_lim_neg;

    always_comb begin
        if (s1_clamp_lo) begin
            s1_sum = SUM_W'(s1_lim_neg);
        end else if (s1_clamp_hi) begin
            s1_sum = SUM_W'(s1_lim_pos);
        end else begin
            s1_sum = SUM_W'(s1_raw);
        end
    end

    assign s1_delta = DELTA_W'(s1_err) - DELTA_W'(r_prev_err);

    // ------------------------------------------------------------------
    // Stage 2: three gain products
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]    r_s2_err;
    logic signed [SUM_W-1:0]    r_s2_sum;
    logic signed [DELTA_W-1:0]  r_s2_delta;
    logic                       r_s2_clamp;

    logic signed [PROD_P_W-1:0] s2_prod_p;
    logic signed [PROD_I_W-1:0] s2_prod_i;
    logic signed [PROD_D_W-1:0] s2_prod_d;

    assign s2_prod_p = PROD_P_W'(signed'({1'b0, r_prop_gain}))  * PROD_P_W'(r_s2_err);
    assign s2_prod_i = PROD_I_W'(signed'({1'b0, r_integ_gain})) * PROD_I_W'(r_s2_sum);
    assign s2_prod_d = PROD_D_W'(signed'({1'b0, r_deriv_gain})) * PROD_D_W'(r_s2_delta);

    // ------------------------------------------------------------------
    // Stage 3: sum, truncate toward zero, saturate, update pulse level
    // ------------------------------------------------------------------
    logic signed [PROD_P_W-1:0] r_s3_prod_p;
    logic signed [PROD_I_W-1:0] r_s3_prod_i;
    logic signed [PROD_D_W-1:0] r_s3_prod_d;
    logic                       r_s3_clamp;
    logic [PULSE_W-1:0]         r_pulse_level;

    logic signed [ACC_W-1:0]  s3_acc;
    logic signed [ACC_W-1:0]  s3_quot;
    logic                     s3_ovf;
    logic signed [CORR_W-1:0] s3_corr;
    logic [PULSE_W-1:0]       s3_lo;
    logic [PULSE_W-1:0]       s3_hi;
    logic signed [LVL_W-1:0]  s3_lvl;
    logic [PULSE_W-1:0]       n_pulse_level;

    assign s3_acc = ACC_W'(r_s3_prod_p) + ACC_W'(r_s3_prod_i) + ACC_W'(r_s3_prod_d);
    // Bias negatives before the arithmetic shift to round toward zero.
    assign s3_quot = (s3_acc + (s3_acc[ACC_W-1] ? signed'(TRUNC_BIAS) : signed'(ACC_W'(0))))
                     >>> GAIN_FRAC_BITS;
    assign s3_ovf  = !((&s3_quot[ACC_W-1:CORR_W-1]) || !(|s3_quot[ACC_W-1:CORR_W-1]));

    always_comb begin
        if (s3_ovf) begin
            s3_corr = s3_quot[ACC_W-1] ? {1'b1, {(CORR_W-1){1'b0}}}
                                       : {1'b0, {(CORR_W-1){1'b1}}};
        end else begin
            s3_corr = s3_quot[CORR_W-1:0];
        end
    end

    assign s3_lo  = (r_floor > PULSE_MAX) ? PULSE_MAX : r_floor;
    assign s3_hi  = (r_ceiling > PULSE_MAX) ? PULSE_MAX : r_ceiling;
    assign s3_lvl = signed'(LVL_W'(r_pulse_level)) - LVL_W'(s3_corr);

    // Floor test wins over the ceiling when the two cross.
    always_comb begin
        if (!r_cool_en) begin
            n_pulse_level = '0;
        end else if (s3_lvl < signed'(LVL_W'(s3_lo))) begin
            n_pulse_level = s3_lo;
        end else if (s3_lvl > signed'(LVL_W'(s3_hi))) begin
            n_pulse_level = s3_hi;
        end else begin
            n_pulse_level = s3_lvl[PULSE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PULSE_W-1:0]       r_out_pulse;
    logic signed [CORR_W-1:0] r_out_corr;
    logic                     r_out_clamp;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_clamp, r_out_corr, r_out_pulse});

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_s3_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_err_sum     <= '0;
            r_prev_err    <= '0;
            r_pulse_level <= PULSE_RESET;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_s3_valid  <= n_s3_valid;
            r_out_valid <= n_out_valid;
            if (s1_mv) begin
                r_err_sum  <= s1_sum;
                r_prev_err <= s1_err;
            end
            if (s3_mv) begin
                r_pulse_level <= n_pulse_level;
            end
        end
    end

    // Payload registers: load when the stage takes an item, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_temp <= i_s_axis_tdata[TEMP_BITS-1:0];
        end
        if (s1_mv) begin
            r_s2_err   <= s1_err;
            r_s2_sum   <= s1_sum;
            r_s2_delta <= s1_delta;
            r_s2_clamp <= s1_clamp_hi || s1_clamp_lo;
        end
        if (s2_mv) begin
            r_s3_prod_p <= s2_prod_p;
            r_s3_prod_i <= s2_prod_i;
            r_s3_prod_d <= s2_prod_d;
            r_s3_clamp  <= r_s2_clamp;
        end
        if (s3_mv) begin
            r_out_pulse <= n_pulse_level;
            r_out_corr  <= s3_corr;
            r_out_clamp <= r_s3_clamp;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic clamp_lo_chk;
    logic win_chk_en;
    logic pulse_in_win;
    logic all_full;

    assign clamp_lo_chk = s1_mv && s1_clamp_lo && (r_limit != '0);
    assign win_chk_en   = s3_mv && r_cool_en && (r_floor <= r_ceiling)
                          && (r_ceiling <= PULSE_MAX);
    assign pulse_in_win = (n_pulse_level >= r_floor) && (n_pulse_level <= r_ceiling);
    assign all_full     = r_s1_valid && r_s2_valid && r_s3_valid && r_out_valid;

    `PIDC_ASSERT_NEXT(a_clamp_hi_sum, s1_mv && s1_clamp_hi, !r_err_sum[SUM_W-1] && r_s2_clamp)
    `PIDC_ASSERT_NEXT(a_clamp_lo_sum, clamp_lo_chk, r_err_sum[SUM_W-1] && r_s2_clamp)
    `PIDC_ASSERT_NEXT(a_cool_off_zero, s3_mv && !r_cool_en, ~|r_pulse_level && ~|r_out_pulse)
    `PIDC_ASSERT_SAME(a_pulse_window, win_chk_en, pulse_in_win)
    `PIDC_ASSERT_SAME(a_stall_full, !o_s_axis_tready, all_full)

endmodule
